[hw/rtl/lfl_pkg.sv]
`timescale 1ns / 1ps

package lfl_pkg;

  // Operation codes carried on in_tuser
  typedef enum logic [1:0] {
    ACT_TOUCH  = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_EVICT  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  // Fixed field widths of the stream payload
  localparam int FRAME_W = 6;
  localparam int PID_IN_W = 8;
  localparam int OCC_W = 7;
  localparam int ACTION_W = 2;

  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 16;

endpackage

[hw/rtl/lru_frame_list_with_pid_eviction.sv]
`timescale 1ns / 1ps

// Recency list of up to FRAMES frames, oldest at position 0, each entry holding
// a frame index and its owner's process id in one single-port-read RAM. A
// request is touch (move or append a frame as most recent), remove, evict the
// oldest frame of a process, or no-op. Each request walks the whole list once
// through the RAM read port: entry i is read, compared, and once the match is
// seen every later entry is written back one slot lower, which closes the gap.
// The walk reads one entry per cycle, and an empty list skips it; the request
// then waits to finish until the output register is free. One result is
// returned per request; the next request is taken while the previous result
// still waits in the output register.
module lru_frame_list_with_pid_eviction #(
  parameter int FRAMES   = 64,
  parameter int PID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata fields, low bit first: frame[5:0], pid[13:6], zero pad[15:14]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // in_tuser fields: action[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata fields, low bit first: victim_frame[5:0], occupancy[12:6],
  // zero pad[15:13]
  output logic [15:0] out_tdata,
  // out_tuser fields: found[0]
  output logic        out_tuser
);

  localparam int AW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam int EW = lfl_pkg::FRAME_W + PID_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]               pidx_r, pidx_nxt;
  logic                        pend_r, pend_nxt;
  logic                        found_r, found_nxt;
  logic [lfl_pkg::FRAME_W-1:0] victim_r, victim_nxt;
  lfl_pkg::action_t            act_r, act_nxt;
  logic [lfl_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic [PID_BITS-1:0]         pid_r, pid_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [lfl_pkg::OCC_W-1:0]   occ_out_r, occ_out_nxt;
  logic [lfl_pkg::FRAME_W-1:0] vic_out_r, vic_out_nxt;
  logic                        fnd_out_r, fnd_out_nxt;

  logic                        in_acc;
  logic [lfl_pkg::FRAME_W-1:0] in_frame;
  logic [PID_BITS+lfl_pkg::PID_IN_W-1:0] in_pid_ext;
  logic [PID_BITS-1:0]         in_pid;

  logic                        ram_wr_en;
  logic [AW-1:0]               ram_wr_addr;
  logic [EW-1:0]               ram_wr_data;
  logic                        ram_rd_en;
  logic [AW-1:0]               ram_rd_addr;
  logic [EW-1:0]               ram_rd_data;

  logic [lfl_pkg::FRAME_W-1:0] ent_frame;
  logic [PID_BITS-1:0]         ent_pid;
  logic                        ent_match;
  logic [CW-1:0]               cnt_after;
  logic [CW+lfl_pkg::OCC_W-1:0] occ_ext;
  logic                        do_append;
  logic                        out_free;

  // Unpack the request; pid is zero-extended then cut to PID_BITS
  assign in_frame   = in_tdata[lfl_pkg::FRAME_W-1:0];
  assign in_pid_ext = {{PID_BITS{1'b0}},
                       in_tdata[lfl_pkg::FRAME_W +: lfl_pkg::PID_IN_W]};
  assign in_pid     = in_pid_ext[PID_BITS-1:0];
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;

  // Split the entry read back from the list RAM
  assign ent_frame = ram_rd_data[lfl_pkg::FRAME_W-1:0];
  assign ent_pid   = ram_rd_data[EW-1:lfl_pkg::FRAME_W];

  always_comb begin
    unique case (act_r) inside
      lfl_pkg::ACT_TOUCH,
      lfl_pkg::ACT_REMOVE: ent_match = (ent_frame == frame_r);
      lfl_pkg::ACT_EVICT:  ent_match = (ent_pid == pid_r);
      default:             ent_match = 1'b0;
    endcase
  end

  assign out_free  = !out_valid_r || out_tready;
  assign cnt_after = cnt_r - CW'(found_r);
  assign do_append = (act_r == lfl_pkg::ACT_TOUCH) &&
                     (found_r || (cnt_r < CW'(FRAMES)));
  assign occ_ext   = {{lfl_pkg::OCC_W{1'b0}}, cnt_nxt};

  // Sequencer: walk the list, shift entries down past the match, then finish
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    pidx_nxt      = pidx_r;
    pend_nxt      = 1'b0;
    found_nxt     = found_r;
    victim_nxt    = victim_r;
    act_nxt       = act_r;
    frame_nxt     = frame_r;
    pid_nxt       = pid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    occ_out_nxt   = occ_out_r;
    vic_out_nxt   = vic_out_r;
    fnd_out_nxt   = fnd_out_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = rd_idx_r[AW-1:0];
    ram_wr_en     = 1'b0;
    ram_wr_addr   = pidx_r - AW'(1);
    ram_wr_data   = ram_rd_data;

    // Compare or move the entry that arrived from the RAM
    if (pend_r) begin
      if (found_r) begin
        ram_wr_en = 1'b1;
      end else if (ent_match) begin
        found_nxt  = 1'b1;
        victim_nxt = ent_frame;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt    = lfl_pkg::action_t'(in_tuser);
          frame_nxt  = in_frame;
          pid_nxt    = in_pid;
          found_nxt  = 1'b0;
          rd_idx_nxt = '0;
          if ((in_tuser == lfl_pkg::ACT_TOUCH) || (in_tuser == lfl_pkg::ACT_REMOVE)) begin
            victim_nxt = in_frame;
          end else begin
            victim_nxt = '0;
          end
          state_nxt = (cnt_r == '0) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        ram_rd_en  = 1'b1;
        pend_nxt   = 1'b1;
        pidx_nxt   = rd_idx_r[AW-1:0];
        rd_idx_nxt = rd_idx_r + CW'(1);
        if (rd_idx_r == cnt_r - CW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cnt_nxt = cnt_after;
          if (do_append) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_after[AW-1:0];
            ram_wr_data = {pid_r, frame_r};
            cnt_nxt     = cnt_after + CW'(1);
          end
          out_valid_nxt = 1'b1;
          fnd_out_nxt   = found_r;
          vic_out_nxt   = victim_r;
          occ_out_nxt   = occ_ext[lfl_pkg::OCC_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, list count and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r  <= rd_idx_nxt;
    pidx_r    <= pidx_nxt;
    found_r   <= found_nxt;
    victim_r  <= victim_nxt;
    act_r     <= act_nxt;
    frame_r   <= frame_nxt;
    pid_r     <= pid_nxt;
    occ_out_r <= occ_out_nxt;
    vic_out_r <= vic_out_nxt;
    fnd_out_r <= fnd_out_nxt;
  end

  // Recency list storage: {pid, frame} per position
  lfl_ram #(
    .WIDTH (EW),
    .DEPTH (FRAMES)
  ) u_list_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = fnd_out_r;
  assign out_tdata  = {{(lfl_pkg::OUT_DATA_W - lfl_pkg::OCC_W - lfl_pkg::FRAME_W){1'b0}},
                       occ_out_r, vic_out_r};

  // List never holds more than FRAMES entries
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(FRAMES))
    else $error("list count above FRAMES");

  // Count changes only when a request finishes
  a_cnt_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> $past(state_r == S_FIN))
    else $error("list count changed outside finish");

  // No RAM write while idle
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_wr_en)
    else $error("list write while idle");

  // A gap-closing write stays below the current count
  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr_en && state_r != S_FIN) |-> (CW'(ram_wr_addr) < cnt_r))
    else $error("shift write beyond list");

  // An accepted request blocks the input on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input ready right after accept");

endmodule

[hw/rtl/lfl_ram.sv]
`timescale 1ns / 1ps

module lfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[tb/sv/lru_frame_list_with_pid_eviction_tb.sv]
`timescale 1ns / 1ps

module lru_frame_list_with_pid_eviction_tb;

  localparam int LIST_DEPTH   = 64;
  localparam int DIR_ROWS     = 24;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_AFTER   = 150;

  typedef logic [lfl_pkg::FRAME_W-1:0]  frame_t;
  typedef logic [lfl_pkg::PID_IN_W-1:0] pid_t;

  typedef struct packed {
    logic                      found;
    logic [lfl_pkg::FRAME_W-1:0] victim;
    logic [lfl_pkg::OCC_W-1:0]   occ;
  } frame_result_t;

  typedef struct {
    lfl_pkg::action_t act;
    frame_t           frame;
    pid_t             pid;
    bit               typed;
    frame_result_t    res;
  } dir_row_t;

  typedef enum {PH_FILL, PH_MIX, PH_DRAIN} phase_t;
  typedef enum {RDY_OPEN, RDY_HALF, RDY_SPARSE} ready_mode_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [lfl_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [lfl_pkg::ACTION_W-1:0]   in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [lfl_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;

  // Predicted recency list, oldest entry at index 0
  frame_t lru_frames [LIST_DEPTH];
  pid_t   lru_pids [LIST_DEPTH];
  int     lru_count;

  frame_result_t pending_results [$];
  dir_row_t      dir_rows [DIR_ROWS];
  int            fail_count = 0;
  int            results_seen = 0;
  int            cycle_count = 0;
  int            burst_left = 0;

  lru_frame_list_with_pid_eviction #(
    .FRAMES   (LIST_DEPTH),
    .PID_BITS (lfl_pkg::PID_IN_W)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Position of a frame in the predicted list, or the count if absent
  function automatic int frame_pos(input frame_t f);
    for (int i = 0; i < lru_count; i++)
      if (lru_frames[i] == f) return i;
    return lru_count;
  endfunction

  // Close the gap at pos by moving later entries one slot down
  function automatic void lru_drop(input int pos);
    for (int i = pos; i + 1 < lru_count; i++) begin
      lru_frames[i] = lru_frames[i + 1];
      lru_pids[i]   = lru_pids[i + 1];
    end
    lru_count--;
  endfunction

  // Apply one request to the predicted list and work out its result
  function automatic void lru_apply(input lfl_pkg::action_t act, input frame_t f,
                                    input pid_t p, output frame_result_t r);
    int pos;
    int i;
    r = '0;
    case (act)
      lfl_pkg::ACT_TOUCH: begin
        r.victim = f;
        pos = frame_pos(f);
        if (pos < lru_count) begin
          r.found = 1'b1;
          lru_drop(pos);
        end
        if (r.found || lru_count < LIST_DEPTH) begin
          lru_frames[lru_count] = f;
          lru_pids[lru_count]   = p;
          lru_count++;
        end
      end
      lfl_pkg::ACT_REMOVE: begin
        r.victim = f;
        pos = frame_pos(f);
        if (pos < lru_count) begin
          r.found = 1'b1;
          lru_drop(pos);
        end
      end
      lfl_pkg::ACT_EVICT: begin
        // scan newest to oldest so the oldest owner wins
        pos = lru_count;
        for (i = lru_count - 1; i >= 0; i--)
          if (lru_pids[i] == p) pos = i;
        if (pos < lru_count) begin
          r.found  = 1'b1;
          r.victim = lru_frames[pos];
          lru_drop(pos);
        end
      end
      default: ;
    endcase
    r.occ = lru_count[lfl_pkg::OCC_W-1:0];
  endfunction

  // Offer one request in bursts with random gaps, then record its result
  task automatic push_req(input lfl_pkg::action_t act, input frame_t f,
                          input pid_t p, input bit typed,
                          input frame_result_t typed_res);
    frame_result_t pred;
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(lfl_pkg::IN_DATA_W - lfl_pkg::FRAME_W - lfl_pkg::PID_IN_W){1'b0}}, p, f};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    lru_apply(act, f, p, pred);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // Compare each accepted result with the oldest pending one
  always @(posedge clk) begin : check_results
    frame_result_t want;
    frame_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got.found  = out_tuser;
      got.victim = out_tdata[lfl_pkg::FRAME_W-1:0];
      got.occ    = out_tdata[lfl_pkg::FRAME_W+lfl_pkg::OCC_W-1:lfl_pkg::FRAME_W];
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: found %0d victim %0d occupancy %0d",
                   got.found, got.victim, got.occ);
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found || got.victim !== want.victim ||
            got.occ !== want.occ) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: found %0d/%0d victim %0d/%0d occupancy %0d/%0d (exp/got)",
                     results_seen, want.found, got.found, want.victim, got.victim,
                     want.occ, got.occ);
        end
      end
    end
  end

  // Stall the result side on its own pattern, with one long hold-off
  initial begin : result_ready
    ready_mode_t mode;
    int mode_left;
    bit held;
    out_tready = 1'b0;
    mode = RDY_OPEN;
    mode_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 300);
          case ($urandom_range(0, 2))
            0:       mode = RDY_OPEN;
            1:       mode = RDY_HALF;
            default: mode = RDY_SPARSE;
          endcase
        end
        mode_left--;
        case (mode)
          RDY_OPEN: out_tready <= 1'b1;
          RDY_HALF: out_tready <= ($urandom_range(0, 1) == 1);
          default:  out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lru_frame_list_with_pid_eviction_tb: errors");
    $finish;
  end

  initial begin : stimulus
    phase_t           plan [6];
    int               plan_len [6];
    pid_t             pid_pool [4];
    frame_result_t    none;
    lfl_pkg::action_t act;
    frame_t           f;
    pid_t             p;
    int               r;
    int               sel;
    int               t_lim;
    int               rm_lim;
    int               ev_lim;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = lfl_pkg::ACT_NOP;
    lru_count = 0;
    none      = '0;

    // Directed rows; typed results where they follow at a glance
    dir_rows = '{
      '{lfl_pkg::ACT_TOUCH,  6'd0,  8'h00, 1'b1, '{1'b0, 6'd0,  7'd1}},
      '{lfl_pkg::ACT_TOUCH,  6'd63, 8'hFF, 1'b1, '{1'b0, 6'd63, 7'd2}},
      '{lfl_pkg::ACT_TOUCH,  6'd0,  8'hAA, 1'b1, '{1'b1, 6'd0,  7'd2}},
      '{lfl_pkg::ACT_EVICT,  6'd21, 8'hAA, 1'b1, '{1'b1, 6'd0,  7'd1}},
      '{lfl_pkg::ACT_EVICT,  6'd63, 8'h55, 1'b1, '{1'b0, 6'd0,  7'd1}},
      '{lfl_pkg::ACT_REMOVE, 6'd5,  8'h00, 1'b1, '{1'b0, 6'd5,  7'd1}},
      '{lfl_pkg::ACT_REMOVE, 6'd63, 8'hFF, 1'b1, '{1'b1, 6'd63, 7'd0}},
      '{lfl_pkg::ACT_REMOVE, 6'd63, 8'hFF, 1'b1, '{1'b0, 6'd63, 7'd0}},
      '{lfl_pkg::ACT_EVICT,  6'd0,  8'hFF, 1'b1, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_NOP,    6'd63, 8'hFF, 1'b1, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_TOUCH,  6'd10, 8'h01, 1'b0, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_TOUCH,  6'd11, 8'h02, 1'b0, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_TOUCH,  6'd12, 8'h01, 1'b0, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_TOUCH,  6'd10, 8'h03, 1'b0, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_EVICT,  6'd10, 8'h01, 1'b0, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_TOUCH,  6'd42, 8'h80, 1'b0, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_TOUCH,  6'd21, 8'h7F, 1'b0, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_REMOVE, 6'd10, 8'h00, 1'b0, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_REMOVE, 6'd21, 8'h00, 1'b0, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_REMOVE, 6'd11, 8'h00, 1'b0, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_EVICT,  6'd0,  8'h80, 1'b0, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_NOP,    6'd42, 8'h55, 1'b1, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_TOUCH,  6'd63, 8'h00, 1'b0, '{1'b0, 6'd0,  7'd0}},
      '{lfl_pkg::ACT_EVICT,  6'd0,  8'h00, 1'b0, '{1'b0, 6'd0,  7'd0}}
    };
    plan     = '{PH_FILL, PH_MIX, PH_DRAIN, PH_FILL, PH_MIX, PH_DRAIN};
    plan_len = '{110, 100, 100, 110, 100, 80};

    // Hold reset, release it away from the active edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < DIR_ROWS; n++)
      push_req(dir_rows[n].act, dir_rows[n].frame, dir_rows[n].pid,
               dir_rows[n].typed, dir_rows[n].res);

    // Random phases: fill toward full, mix, then drain
    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 4; k++) pid_pool[k] = pid_t'($urandom_range(0, 255));
      case (plan[ph])
        PH_FILL:  begin t_lim = 75; rm_lim = 83; ev_lim = 93; end
        PH_MIX:   begin t_lim = 40; rm_lim = 65; ev_lim = 92; end
        default:  begin t_lim = 15; rm_lim = 55; ev_lim = 95; end
      endcase
      for (int k = 0; k < plan_len[ph]; k++) begin
        r   = $urandom_range(0, 99);
        sel = $urandom_range(0, 3);
        f   = frame_t'($urandom_range(0, 63));
        p   = ($urandom_range(0, 4) == 0) ? pid_t'($urandom_range(0, 255)) : pid_pool[sel];
        if (r < t_lim) begin
          act = lfl_pkg::ACT_TOUCH;
          if (lru_count < LIST_DEPTH && ((plan[ph] == PH_FILL) ? (sel != 0) : (sel == 0))) begin
            // walk to the next frame that is not listed yet
            while (frame_pos(f) < lru_count) f = f + frame_t'(1);
          end else if (lru_count > 0 && sel >= 2) begin
            f = lru_frames[$urandom_range(0, lru_count - 1)];
          end
        end else if (r < rm_lim) begin
          act = lfl_pkg::ACT_REMOVE;
          if (lru_count > 0 && $urandom_range(0, 9) < 7)
            f = lru_frames[$urandom_range(0, lru_count - 1)];
        end else if (r < ev_lim) begin
          act = lfl_pkg::ACT_EVICT;
          if (lru_count > 0 && $urandom_range(0, 9) < 7)
            p = lru_pids[$urandom_range(0, lru_count - 1)];
        end else begin
          act = lfl_pkg::ACT_NOP;
        end
        push_req(act, f, p, 1'b0, none);
      end
      // Drop valid and wait until every pending result has arrived
      @(negedge clk);
      in_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clk);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count += pending_results.size();
    if (fail_count == 0)
      $display("lru_frame_list_with_pid_eviction_tb: clean");
    else
      $display("lru_frame_list_with_pid_eviction_tb: errors");
    $finish;
  end

endmodule
